### hw/rtl/twh_pkg.sv
// shared types and codes for the three-way handshake engine
package twh_pkg;

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_RX    = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;
   localparam logic [1:0] ACT_SPARE = 2'd3;

   localparam logic [1:0] PK_CON   = 2'd0;
   localparam logic [1:0] PK_SYN   = 2'd1;
   localparam logic [1:0] PK_ACK   = 2'd2;
   localparam logic [1:0] PK_OTHER = 2'd3;

   localparam logic [1:0] ST_IDLE      = 2'd0;
   localparam logic [1:0] ST_WAIT_SYN  = 2'd1;
   localparam logic [1:0] ST_WAIT_ACK  = 2'd2;
   localparam logic [1:0] ST_CONNECTED = 2'd3;

   localparam logic [1:0] RES_NONE = 2'd0;
   localparam logic [1:0] RES_OK   = 2'd1;
   localparam logic [1:0] RES_FAIL = 2'd2;

   localparam int          DELAY_W           = 16;
   localparam int          ATT_W             = 8;
   localparam logic [15:0] RETRY_DELAY_RESET = 16'd1000;
   localparam logic [0:0]  REG_RETRY_DELAY   = 1'b0;

   typedef struct packed {
      logic [1:0]         hs_state;
      logic               instigator;
      logic [ATT_W-1:0]   attempts_left;
      logic [DELAY_W-1:0] timer_left;
   } state_type;

   typedef struct packed {
      logic [1:0]       action;
      logic [1:0]       packet_type;
      logic [ATT_W-1:0] attempt_limit;
   } item_type;

   typedef struct packed {
      logic       send_valid;
      logic [1:0] send_type;
      logic [1:0] connect_result;
      logic       handled;
      logic [1:0] link_state;
   } result_type;

endpackage

### hw/rtl/twh_next.sv
// next link state and result word for one input word
module twh_next (
   input  twh_pkg::item_type             item,
   input  twh_pkg::state_type            cur,
   input  logic [twh_pkg::DELAY_W-1:0]   retry_delay,
   output twh_pkg::state_type            nxt,
   output twh_pkg::result_type           res
);
   import twh_pkg::*;

   logic [DELAY_W-1:0] timer_dec;

   assign timer_dec = cur.timer_left - DELAY_W'(1);

   always_comb begin
      nxt = cur;
      res = '0;
      case (item.action)
         ACT_START: begin
            res.send_valid    = 1'b1;
            res.send_type     = PK_CON;
            nxt.timer_left    = retry_delay;
            nxt.hs_state      = ST_WAIT_SYN;
            nxt.instigator    = 1'b1;
            nxt.attempts_left = item.attempt_limit;
         end
         ACT_RX: begin
            case (item.packet_type)
               PK_CON: begin
                  res.handled = 1'b1;
                  if (!cur.instigator) begin
                     res.send_valid = 1'b1;
                     res.send_type  = PK_SYN;
                     nxt.timer_left = retry_delay;
                     if (cur.hs_state == ST_IDLE) begin
                        nxt.hs_state = ST_WAIT_ACK;
                     end
                  end
               end
               PK_SYN: begin
                  res.handled = 1'b1;
                  if (cur.instigator) begin
                     res.send_valid = 1'b1;
                     res.send_type  = PK_ACK;
                     nxt.timer_left = retry_delay;
                     if (cur.hs_state == ST_WAIT_SYN) begin
                        res.connect_result = RES_OK;
                        nxt.hs_state       = ST_CONNECTED;
                     end
                  end
               end
               PK_ACK: begin
                  res.handled = 1'b1;
                  if (cur.hs_state == ST_WAIT_ACK) begin
                     nxt.hs_state = ST_CONNECTED;
                  end
               end
               default: begin
               end
            endcase
         end
         ACT_TICK: begin
            if (cur.timer_left != '0) begin
               nxt.timer_left = timer_dec;
               if (timer_dec == '0 && cur.hs_state inside {ST_WAIT_SYN, ST_WAIT_ACK}) begin
                  if (cur.instigator && cur.attempts_left <= ATT_W'(1)) begin
                     res.connect_result = RES_FAIL;
                     nxt.hs_state       = ST_IDLE;
                     nxt.instigator     = 1'b0;
                     nxt.attempts_left  = '0;
                     nxt.timer_left     = '0;
                  end else begin
                     if (cur.instigator) begin
                        nxt.attempts_left = cur.attempts_left - ATT_W'(1);
                     end
                     res.send_valid = 1'b1;
                     res.send_type  = (cur.hs_state == ST_WAIT_SYN) ? PK_CON : PK_SYN;
                     nxt.timer_left = retry_delay;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      res.link_state = nxt.hs_state;
   end

endmodule

### hw/rtl/three_way_handshake_fsm_core.sv
// three-way handshake engine: input register, state update, result register
// an accepted word is held in the input register, passes the state update and is then registered in the result register
// throughput: one word per cycle while the consumer does not stall; the state update sits between the two registers
// the result register frees its stall path when the consumer takes the word
// reset clears the link state, flags, timer and valid bits; retry_delay returns to 1000
module three_way_handshake_fsm_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [1:0]  req_packet_type,
   input  logic [7:0]  req_attempt_limit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_send_valid,
   output logic [1:0]  rsp_send_type,
   output logic [1:0]  rsp_connect_result,
   output logic        rsp_handled,
   output logic [1:0]  rsp_link_state,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import twh_pkg::*;

   logic               in_valid_ff, in_valid_in;
   item_type           item_ff;
   state_type          state_ff, state_in;
   result_type         res_ff, res_in;
   logic               out_valid_ff, out_valid_in;
   logic [DELAY_W-1:0] retry_delay_ff;
   logic               advance, fire, req_take, csr_write;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   twh_next u_next (
      .item        (item_ff),
      .cur         (state_ff),
      .retry_delay (retry_delay_ff),
      .nxt         (state_in),
      .res         (res_in)
   );

   // register file
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_RETRY_DELAY);
   assign prdata    = (paddr[2] == REG_RETRY_DELAY) ? {16'd0, retry_delay_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         state_ff       <= '0;
         retry_delay_ff <= RETRY_DELAY_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            state_ff <= state_in;
         end
         if (csr_write) begin
            retry_delay_ff <= pwdata[DELAY_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.action        <= req_action;
         item_ff.packet_type   <= req_packet_type;
         item_ff.attempt_limit <= req_attempt_limit;
      end
      if (fire) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_send_valid     = res_ff.send_valid;
   assign rsp_send_type      = res_ff.send_type;
   assign rsp_connect_result = res_ff.connect_result;
   assign rsp_handled        = res_ff.handled;
   assign rsp_link_state     = res_ff.link_state;

endmodule

### hw/rtl/twh_checker.sv
// port-level checks for the handshake engine, bound to the top level
module twh_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_send_valid,
   input logic [1:0] rsp_send_type,
   input logic [1:0] rsp_connect_result,
   input logic [1:0] rsp_link_state
);
   import twh_pkg::*;

   // a held result word keeps its link state, connect result and send valid bit
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_link_state)
         && $stable(rsp_connect_result) && $stable(rsp_send_valid))
      else $error("result word changed while stalled");

   a_idle_type: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_send_valid |-> rsp_send_type == PK_CON)
      else $error("send type set without a send");

   a_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_connect_result == RES_OK |->
         rsp_link_state == ST_CONNECTED && rsp_send_valid && rsp_send_type == PK_ACK)
      else $error("connected report without ACK and connected state");

   a_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_connect_result == RES_FAIL |->
         rsp_link_state == ST_IDLE && !rsp_send_valid)
      else $error("failure report without return to not connected");

endmodule

bind three_way_handshake_fsm_core twh_checker u_twh_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_send_valid     (rsp_send_valid),
   .rsp_send_type      (rsp_send_type),
   .rsp_connect_result (rsp_connect_result),
   .rsp_link_state     (rsp_link_state)
);

### bench/three_way_handshake_fsm_core_test.sv
// self-checking testbench for the three-way handshake engine with retransmit
module three_way_handshake_fsm_core_test;
   import twh_pkg::*;

   localparam int CLOCK_LIMIT = 100000;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_WORDS = 85;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = '0;
   logic [1:0]  req_packet_type = '0;
   logic [7:0]  req_attempt_limit = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_send_valid;
   logic [1:0]  rsp_send_type;
   logic [1:0]  rsp_connect_result;
   logic        rsp_handled;
   logic [1:0]  rsp_link_state;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   three_way_handshake_fsm_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_packet_type    (req_packet_type),
      .req_attempt_limit  (req_attempt_limit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_send_valid     (rsp_send_valid),
      .rsp_send_type      (rsp_send_type),
      .rsp_connect_result (rsp_connect_result),
      .rsp_handled        (rsp_handled),
      .rsp_link_state     (rsp_link_state),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mirrored link state
   logic [1:0]         m_state = ST_IDLE;
   logic               m_instigator = 1'b0;
   logic [ATT_W-1:0]   m_attempts = '0;
   logic [DELAY_W-1:0] m_timer = '0;
   logic [DELAY_W-1:0] m_delay = RETRY_DELAY_RESET;

   result_type awaited_replies[$];
   result_type want;
   int words_sent = 0;
   int words_checked = 0;
   int mismatches = 0;
   int burst_left = 0;
   bit gaps_on = 1'b0;

   // receiver stall control, written by the tests at the clock edge
   int stall_mode = 0;
   int hold_ticket = 0;
   int seen_ticket = 0;
   int hold_left = 0;
   int stall_phase = 0;

   function automatic result_type handshake_outcome(logic [1:0] act, logic [1:0] pkt,
                                                    logic [7:0] att);
      result_type r;
      r = '0;
      case (act)
         ACT_START: begin
            r.send_valid = 1'b1;
            r.send_type = PK_CON;
            m_timer = m_delay;
            m_state = ST_WAIT_SYN;
            m_instigator = 1'b1;
            m_attempts = att;
         end
         ACT_RX: begin
            if (pkt == PK_CON) begin
               r.handled = 1'b1;
               if (!m_instigator) begin
                  r.send_valid = 1'b1;
                  r.send_type = PK_SYN;
                  m_timer = m_delay;
                  if (m_state == ST_IDLE) m_state = ST_WAIT_ACK;
               end
            end else if (pkt == PK_SYN) begin
               r.handled = 1'b1;
               if (m_instigator) begin
                  r.send_valid = 1'b1;
                  r.send_type = PK_ACK;
                  m_timer = m_delay;
                  if (m_state == ST_WAIT_SYN) begin
                     r.connect_result = RES_OK;
                     m_state = ST_CONNECTED;
                  end
               end
            end else if (pkt == PK_ACK) begin
               r.handled = 1'b1;
               if (m_state == ST_WAIT_ACK) m_state = ST_CONNECTED;
            end
         end
         ACT_TICK: begin
            if (m_timer != 0) begin
               m_timer = m_timer - 1'b1;
               if (m_timer == 0 && (m_state == ST_WAIT_SYN || m_state == ST_WAIT_ACK)) begin
                  if (m_instigator && m_attempts <= 1) begin
                     r.connect_result = RES_FAIL;
                     m_state = ST_IDLE;
                     m_instigator = 1'b0;
                     m_attempts = '0;
                     m_timer = '0;
                  end else begin
                     if (m_instigator) m_attempts = m_attempts - 1'b1;
                     r.send_valid = 1'b1;
                     r.send_type = (m_state == ST_WAIT_SYN) ? PK_CON : PK_SYN;
                     m_timer = m_delay;
                  end
               end
            end
         end
         default: ;
      endcase
      r.link_state = m_state;
      return r;
   endfunction

   task automatic check_field(string what, logic [31:0] expected, logic [31:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, expected, actual);
         mismatches++;
      end
   endtask

   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_replies.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual link_state %0d",
                     $time, rsp_link_state);
            mismatches++;
         end else begin
            want = awaited_replies.pop_front();
            words_checked++;
            check_field("send_valid", 32'(want.send_valid), 32'(rsp_send_valid));
            check_field("send_type", 32'(want.send_type), 32'(rsp_send_type));
            check_field("connect_result", 32'(want.connect_result),
                        32'(rsp_connect_result));
            check_field("handled", 32'(want.handled), 32'(rsp_handled));
            check_field("link_state", 32'(want.link_state), 32'(rsp_link_state));
         end
      end
   end

   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_ticket != seen_ticket) begin
         seen_ticket <= hold_ticket;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            1: rsp_stall <= 1'($urandom_range(0, 1));
            2: rsp_stall <= (stall_phase % 5) >= 3;
            3: rsp_stall <= $urandom_range(0, 9) < 7;
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   task automatic offer_word(logic [1:0] act, logic [1:0] pkt, logic [7:0] att);
      bit took;
      if (gaps_on && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_action <= act;
      req_packet_type <= pkt;
      req_attempt_limit <= att;
      do begin
         @(negedge clock);
         took = !req_stall;
         @(posedge clock);
      end while (!took);
      awaited_replies.push_back(handshake_outcome(act, pkt, att));
      words_sent++;
   endtask

   task automatic settle_link();
      req_valid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_retry_delay(logic [15:0] value);
      logic        ok;
      logic [31:0] rd;
      settle_link();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 3'(4 * REG_RETRY_DELAY);
      pwdata <= {16'h0, value};
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         ok = pready;
         @(posedge clock);
      end while (!ok);
      m_delay = value;
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         ok = pready;
         rd = prdata;
         @(posedge clock);
      end while (!ok);
      check_field("retry_delay readback", {16'h0, value}, rd);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic logic [1:0] any_pkt();
      return 2'($urandom_range(0, 3));
   endfunction

   function automatic logic [7:0] any_att();
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic test_idle_cases();
      offer_word(ACT_RX, PK_ACK, 8'h00);
      offer_word(ACT_RX, PK_OTHER, 8'hff);
      offer_word(ACT_SPARE, PK_OTHER, 8'hff);
      offer_word(ACT_TICK, PK_CON, 8'h55);
   endtask

   task automatic test_responder_path();
      offer_word(ACT_RX, PK_CON, 8'haa);
      offer_word(ACT_RX, PK_CON, 8'h00);
      offer_word(ACT_RX, PK_ACK, 8'h00);
      offer_word(ACT_RX, PK_SYN, 8'h00);
   endtask

   task automatic test_instigator_path();
      offer_word(ACT_START, PK_ACK, 8'hff);
      offer_word(ACT_RX, PK_CON, 8'h00);
      offer_word(ACT_RX, PK_SYN, 8'h00);
      offer_word(ACT_RX, PK_SYN, 8'h00);
   endtask

   task automatic test_retry_and_failure();
      write_retry_delay(16'd1);
      // zero attempts act as one
      offer_word(ACT_START, PK_CON, 8'h00);
      offer_word(ACT_TICK, PK_CON, 8'h00);
      offer_word(ACT_START, PK_CON, 8'd2);
      offer_word(ACT_TICK, PK_CON, 8'h00);
      offer_word(ACT_TICK, PK_CON, 8'h00);
      // responder resends without limit
      offer_word(ACT_RX, PK_CON, 8'h00);
      offer_word(ACT_TICK, PK_CON, 8'h00);
      offer_word(ACT_TICK, PK_CON, 8'h00);
      offer_word(ACT_RX, PK_ACK, 8'h00);
      offer_word(ACT_TICK, PK_CON, 8'h00);
   endtask

   task automatic test_stopped_timer();
      write_retry_delay(16'd0);
      offer_word(ACT_START, PK_CON, 8'd1);
      offer_word(ACT_TICK, PK_CON, 8'd1);
      offer_word(ACT_RX, PK_SYN, 8'd1);
      settle_link();
   endtask

   task automatic run_session();
      int kind;
      int n;
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
         offer_word(ACT_START, any_pkt(), any_att());
         repeat ($urandom_range(0, 6)) offer_word(ACT_TICK, any_pkt(), any_att());
         offer_word(ACT_RX, PK_SYN, any_att());
         if ($urandom_range(0, 1)) offer_word(ACT_RX, any_pkt(), any_att());
      end else if (kind < 5) begin
         // run the attempts out, ticking until the instigator flag drops or 40 ticks are sent
         offer_word(ACT_START, any_pkt(), 8'($urandom_range(0, 3)));
         n = 0;
         while (m_instigator && n < 40) begin
            offer_word(ACT_TICK, any_pkt(), any_att());
            n++;
         end
      end else if (kind < 8) begin
         offer_word(ACT_RX, PK_CON, any_att());
         repeat ($urandom_range(0, 5)) offer_word(ACT_TICK, any_pkt(), any_att());
         if ($urandom_range(0, 3) != 0) offer_word(ACT_RX, PK_ACK, any_att());
      end else begin
         repeat ($urandom_range(1, 6))
            offer_word(2'($urandom_range(0, 3)), any_pkt(), any_att());
      end
   endtask

   task automatic test_random_traffic();
      logic [15:0] delays [8];
      int          start_count;
      delays = '{16'd1000, 16'd3, 16'd1, 16'd65535, 16'd2, 16'd5, 16'd0, 16'd7};
      foreach (delays[p]) begin
         write_retry_delay(delays[p]);
         stall_mode <= p % 4;
         gaps_on = (p != 4);
         start_count = words_sent;
         while (words_sent - start_count < PHASE_WORDS) run_session();
      end
      settle_link();
   endtask

   task automatic test_backpressure();
      stall_mode <= 0;
      gaps_on = 1'b0;
      hold_ticket <= hold_ticket + 1;
      repeat (24) offer_word(2'($urandom_range(0, 3)), any_pkt(), any_att());
      settle_link();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_idle_cases();
      test_responder_path();
      test_instigator_path();
      test_retry_and_failure();
      test_stopped_timer();
      test_random_traffic();
      test_backpressure();
      settle_link();
      repeat (8) @(posedge clock);
      $display("covered %0d words, %0d results checked, %0d mismatches", words_sent,
               words_checked, mismatches);
      $display("retry delays 0 to 65535, connect, give-up and responder runs, stalls and gaps");
      if (mismatches == 0 && awaited_replies.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #(CLOCK_LIMIT * 20);
      $display("tb: failure");
      $finish;
   end

endmodule
